/* rtl/urs_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the ultrasonic range sequencer.
// No dependencies; used by every other file of the block.
package urs_pkg;

  localparam int DIST_W         = 16;
  localparam int COUNT_IN_W     = 16;
  localparam int TICK_W         = 8;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int SCALE_MUL      = 1000;
  localparam int SCALE_DIV      = 11029;
  localparam int SCALE_DIV_BITS = $clog2(SCALE_DIV);

  localparam logic [DIST_W-1:0] MAX_DIST_RESET     = 16'd4000;
  localparam logic [TICK_W-1:0] WAIT_TICKS_RESET   = 8'd5;
  localparam logic [TICK_W-1:0] SAMPLE_TICKS_RESET = 8'd2;
  localparam logic [TICK_W-1:0] MISS_LIMIT_RESET   = 8'd5;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_MAX_DISTANCE = 2'd0,
    REG_WAIT_TICKS   = 2'd1,
    REG_SAMPLE_TICKS = 2'd2,
    REG_MISS_LIMIT   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_WAIT   = 2'd0,
    PH_TRIG   = 2'd1,
    PH_SAMPLE = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ACT_HOLD   = 2'd0,
    ACT_SCALED = 2'd1,
    ACT_MAX    = 2'd2
  } act_t;

  typedef struct packed {
    logic [DIST_W-1:0] max_distance;
    logic [TICK_W-1:0] wait_ticks;
    logic [TICK_W-1:0] sample_ticks;
    logic [TICK_W-1:0] miss_limit;
  } cfg_t;

  typedef struct packed {
    logic fire;
    act_t act;
    logic have;
  } ctrl_t;

endpackage

/* rtl/urs_if.sv */
`timescale 1ns / 1ps
// Request and result channel interfaces of the ultrasonic range sequencer.
// Depends on urs_pkg for field widths.
interface urs_in_if;
  import urs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  echo_seen;
  logic [COUNT_IN_W-1:0] echo_count;
  modport source (output valid, output echo_seen, output echo_count, input ready);
  modport sink   (input valid, input echo_seen, input echo_count, output ready);
endinterface

interface urs_out_if;
  import urs_pkg::*;
  logic              valid;
  logic              ready;
  logic              fire_trigger;
  logic [DIST_W-1:0] distance_mm;
  logic              distance_valid;
  modport source (output valid, output fire_trigger, output distance_mm,
                  output distance_valid, input ready);
  modport sink   (input valid, input fire_trigger, input distance_mm,
                  input distance_valid, output ready);
endinterface

/* rtl/urs_cfg.sv */
`timescale 1ns / 1ps
// APB-style configuration registers of the ultrasonic range sequencer.
// Depends on urs_pkg.
module urs_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [urs_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [urs_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [urs_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output urs_pkg::cfg_t                     cfg
);
  import urs_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_MAX_DISTANCE: cfg_nxt.max_distance = pwdata[DIST_W-1:0];
        REG_WAIT_TICKS:   cfg_nxt.wait_ticks   = pwdata[TICK_W-1:0];
        REG_SAMPLE_TICKS: cfg_nxt.sample_ticks = pwdata[TICK_W-1:0];
        REG_MISS_LIMIT:   cfg_nxt.miss_limit   = pwdata[TICK_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MAX_DISTANCE: prdata = APB_DATA_W'(cfg_r.max_distance);
      REG_WAIT_TICKS:   prdata = APB_DATA_W'(cfg_r.wait_ticks);
      REG_SAMPLE_TICKS: prdata = APB_DATA_W'(cfg_r.sample_ticks);
      REG_MISS_LIMIT:   prdata = APB_DATA_W'(cfg_r.miss_limit);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_distance <= MAX_DIST_RESET;
      cfg_r.wait_ticks   <= WAIT_TICKS_RESET;
      cfg_r.sample_ticks <= SAMPLE_TICKS_RESET;
      cfg_r.miss_limit   <= MISS_LIMIT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* rtl/urs_ctrl.sv */
`timescale 1ns / 1ps
// Phase sequencer: wait, trigger and sample counting plus miss tracking.
// Depends on urs_pkg.
module urs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic          echo_seen,
  input  urs_pkg::cfg_t cfg,
  output urs_pkg::ctrl_t ctrl
);
  import urs_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [TICK_W-1:0] miss_r, miss_nxt;
  logic              have_r, have_nxt;
  logic [TICK_W-1:0] tick_inc;

  assign tick_inc = tick_r + TICK_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    miss_nxt  = miss_r;
    have_nxt  = have_r;
    ctrl.fire = 1'b0;
    ctrl.act  = ACT_HOLD;
    case (phase_r)
      PH_WAIT: begin
        if (tick_inc >= cfg.wait_ticks) begin
          tick_nxt  = '0;
          phase_nxt = PH_TRIG;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      PH_TRIG: begin
        tick_nxt  = '0;
        phase_nxt = PH_SAMPLE;
        ctrl.fire = 1'b1;
      end
      PH_SAMPLE: begin
        if (tick_inc >= cfg.sample_ticks) begin
          tick_nxt = '0;
          if (echo_seen) begin
            ctrl.act = ACT_SCALED;
            miss_nxt = '0;
          end else if (miss_r < cfg.miss_limit) begin
            miss_nxt = miss_r + TICK_W'(1);
          end else begin
            ctrl.act = ACT_MAX;
          end
          have_nxt  = 1'b1;
          phase_nxt = PH_WAIT;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      default: begin
        tick_nxt  = '0;
        phase_nxt = PH_WAIT;
      end
    endcase
    ctrl.have = have_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      tick_r  <= '0;
      miss_r  <= '0;
      have_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      miss_r  <= miss_nxt;
      have_r  <= have_nxt;
    end
  end

endmodule

/* rtl/urs_scale.sv */
`timescale 1ns / 1ps
// Echo width to millimetres: count*1000/11029 by reciprocal multiply,
// product registered, then shift and saturate. Depends on urs_pkg.
module urs_scale #(
  parameter int COUNT_WIDTH = urs_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic [urs_pkg::COUNT_IN_W-1:0] echo_count,
  input  logic [urs_pkg::DIST_W-1:0]    max_distance,
  output logic [urs_pkg::DIST_W-1:0]    distance
);
  import urs_pkg::*;

  localparam int XW = (COUNT_WIDTH < COUNT_IN_W) ? COUNT_WIDTH : COUNT_IN_W;
  localparam int SH = XW + SCALE_DIV_BITS;
  localparam logic [63:0] RECIP =
    ((64'd1 << SH) * 64'(SCALE_MUL) + 64'(SCALE_DIV) - 64'd1) / 64'(SCALE_DIV);
  localparam int MW = $clog2(RECIP + 64'd1);
  localparam int PW = XW + MW;
  localparam int DW = PW - SH;

  logic [XW-1:0]     x;
  logic [PW-1:0]     prod_r;
  logic [PW-1:0]     prod_nxt;
  logic [DW-1:0]     quot;
  logic [DIST_W-1:0] quot_ext;

  assign x        = echo_count[XW-1:0];
  assign prod_nxt = PW'(x) * PW'(RECIP[MW-1:0]);

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
    end
  end

  assign quot     = prod_r[PW-1:SH];
  assign quot_ext = DIST_W'(quot);
  assign distance = (quot_ext > max_distance) ? max_distance : quot_ext;

endmodule

/* rtl/ultrasonic_range_sequencer.sv */
`timescale 1ns / 1ps
// Top level of the ultrasonic range sequencer: channels, stage control, held distance.
// Depends on urs_pkg, urs_if, urs_cfg, urs_ctrl and urs_scale.
//
//   port     | dir | carries
//   ---------+-----+--------------------------------------------------
//   in_req   | in  | one tick request: echo_seen, echo_count
//   out_rsp  | out | one result per tick: fire_trigger, distance_mm, distance_valid
//   p*       | in  | APB register writes and reads, four registers
//
// Every tick passes through the input stage (sequencer update and the
// reciprocal multiply) and then through the result register; one tick per cycle
// sustained while out_rsp.ready holds. The multiplier sets the path length.
// Synchronous active-low reset; no clearing pass. A stalled result holds in the
// output register while the input stage still takes one further request.
module ultrasonic_range_sequencer #(
  parameter int COUNT_WIDTH = urs_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  urs_in_if.sink                         in_req,
  urs_out_if.source                      out_rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [urs_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [urs_pkg::APB_DATA_W-1:0] pwdata,
  output logic [urs_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import urs_pkg::*;

  cfg_t              cfg;
  ctrl_t             ctrl;
  ctrl_t             s1_ctrl_r;
  logic              s1_valid_r, s1_valid_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_fire_r;
  logic              out_have_r;
  logic [DIST_W-1:0] last_dist_r, last_dist_nxt;
  logic [DIST_W-1:0] scaled;
  logic              in_acc;
  logic              out_adv;
  logic              mv;

  urs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  urs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_acc),
    .echo_seen (in_req.echo_seen),
    .cfg       (cfg),
    .ctrl      (ctrl)
  );

  urs_scale #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_scale (
    .clk          (clk),
    .load         (in_acc),
    .echo_count   (in_req.echo_count),
    .max_distance (cfg.max_distance),
    .distance     (scaled)
  );

  assign out_adv      = !out_valid_r || out_rsp.ready;
  assign mv           = s1_valid_r && out_adv;
  assign in_req.ready = !s1_valid_r || out_adv;
  assign in_acc       = in_req.valid && in_req.ready;

  always_comb begin
    s1_valid_nxt  = in_acc ? 1'b1 : (mv ? 1'b0 : s1_valid_r);
    out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;
    last_dist_nxt = last_dist_r;
    case (s1_ctrl_r.act)
      ACT_SCALED: last_dist_nxt = scaled;
      ACT_MAX:    last_dist_nxt = cfg.max_distance;
      default:    last_dist_nxt = last_dist_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      last_dist_r <= MAX_DIST_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (mv) begin
        last_dist_r <= last_dist_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ctrl_r <= ctrl;
    end
    if (mv) begin
      out_fire_r <= s1_ctrl_r.fire;
      out_have_r <= s1_ctrl_r.have;
    end
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.fire_trigger   = out_fire_r;
  assign out_rsp.distance_mm    = last_dist_r;
  assign out_rsp.distance_valid = out_have_r;

endmodule
